>>> rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// RC4 cipher package
// Shared widths, defaults and input function codes for the RC4 stream block.
// ----------------------------------------------------------------------------
package rc4_pkg;

	// Byte lanes and the permutation table size.
	localparam int BYTE_W     = 8;
	localparam int PERM_DEPTH = 256;

	// Width of the drop count register.
	localparam int DROP_W = 16;

	// Default key store depth.
	localparam int KEY_BYTES_DEFAULT = 256;

	// Input item kinds carried on tuser.
	localparam logic FUNC_KEY  = 1'b0;
	localparam logic FUNC_DATA = 1'b1;

endpackage

>>> rtl/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Byte-serial key loading, key schedule with keystream drop, and data
// encryption or decryption, all working out of one 256-entry table memory.
// ----------------------------------------------------------------------------
// Key bytes arrive with tuser low and are stored one per transfer; the key
// byte with tlast high starts the key schedule. The schedule loads the
// identity permutation, runs the 256 mixing steps, then discards drop_count
// keystream bytes; no item is taken meanwhile. A data byte (tuser high) is
// accepted and worked on the table memory, which has one read and one write
// port and is read three times and written twice per keystream byte. The
// result waits in an output register while the next item is accepted; a
// data byte stalls until that register is free. drop_count is written
// through the cfg channel; the user must write it only while the block is
// idle (the block does not enforce this); it applies to the next schedule.
// Data bytes must only be sent after a key has been loaded.
module rc4_stream_cipher #(
	parameter int MAX_KEY_BYTES = rc4_pkg::KEY_BYTES_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Configuration write channel: drop_count.
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [rc4_pkg::DROP_W-1:0] cfg_data,
	// Input stream.
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [rc4_pkg::BYTE_W-1:0] s_axis_tdata,  // [7:0] data_byte
	input  logic                      s_axis_tlast,  // key_last
	input  logic [0:0]                s_axis_tuser,  // [0] func
	// Output stream.
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [rc4_pkg::BYTE_W-1:0] m_axis_tdata   // [7:0] out_byte
);
	import rc4_pkg::*;

	localparam int KC_W = $clog2(MAX_KEY_BYTES + 1);
	localparam int KA_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int PA_W = $clog2(PERM_DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_KS_RD_I,
		ST_KS_RD_J,
		ST_KS_WR_I,
		ST_KS_WR_J,
		ST_DROP_CHK,
		ST_KG_RD_A,
		ST_KG_RD_B,
		ST_KG_WR_A,
		ST_KG_WR_B
	} state_t;

	state_t                state_q;
	logic [DROP_W-1:0]     drop_count_q;
	logic [DROP_W-1:0]     drop_cnt_q;
	logic [KC_W-1:0]       key_count_q;
	logic [KC_W-1:0]       key_idx_q;
	logic [PA_W-1:0]       i_q;
	logic [PA_W-1:0]       j_q;
	logic [PA_W-1:0]       a_q;
	logic [PA_W-1:0]       b_q;
	logic [BYTE_W-1:0]     si_q;
	logic [BYTE_W-1:0]     sa_q;
	logic [BYTE_W-1:0]     sb_q;
	logic                  fwd_a_q;
	logic                  fwd_b_q;
	logic                  is_data_q;
	logic [BYTE_W-1:0]     data_q;
	logic                  out_valid_q;
	logic [BYTE_W-1:0]     out_byte_q;

	// Table memory and key store.
	logic [BYTE_W-1:0]     perm_mem [PERM_DEPTH];
	logic [BYTE_W-1:0]     key_mem  [MAX_KEY_BYTES];
	logic [BYTE_W-1:0]     perm_rd_q;
	logic [BYTE_W-1:0]     key_rd_q;

	logic                  perm_rd_en;
	logic [PA_W-1:0]       perm_rd_addr;
	logic                  perm_wr_en;
	logic [PA_W-1:0]       perm_wr_addr;
	logic [BYTE_W-1:0]     perm_wr_data;
	logic                  key_wr_en;
	logic                  key_rd_en;

	logic                  in_xfer;
	logic                  out_free;
	logic                  out_load;
	logic [BYTE_W-1:0]     kb;
	logic [PA_W-1:0]       j_new;
	logic [PA_W-1:0]       a_new;
	logic [PA_W-1:0]       b_new;
	logic [PA_W-1:0]       t_addr;
	logic [BYTE_W-1:0]     ks_byte;
	logic [KC_W-1:0]       key_idx_inc;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign out_load      = (state_q == ST_KG_WR_B) && is_data_q && out_free;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;

	// Key byte stored when room remains.
	assign key_wr_en = in_xfer && (s_axis_tuser[0] == FUNC_KEY)
		&& (key_count_q < KC_W'(MAX_KEY_BYTES));
	assign key_rd_en = (state_q == ST_KS_RD_I);

	// Datapath arithmetic for the schedule and keystream steps.
	assign kb          = (key_count_q == '0) ? '0 : key_rd_q;
	assign j_new       = j_q + perm_rd_q + kb;
	assign a_new       = a_q + 1'b1;
	assign b_new       = b_q + perm_rd_q;
	assign t_addr      = sa_q + perm_rd_q;
	assign key_idx_inc = key_idx_q + 1'b1;

	// Keystream byte with forwarding of the swap that overlapped its read.
	always_comb begin
		if (fwd_b_q) begin
			ks_byte = sa_q;
		end else if (fwd_a_q) begin
			ks_byte = sb_q;
		end else begin
			ks_byte = perm_rd_q;
		end
	end

	// Table memory port control.
	always_comb begin
		perm_rd_en   = 1'b0;
		perm_rd_addr = i_q;
		perm_wr_en   = 1'b0;
		perm_wr_addr = i_q;
		perm_wr_data = i_q;
		unique case (state_q)
			ST_INIT: begin
				perm_wr_en = 1'b1;
			end
			ST_KS_RD_I: begin
				perm_rd_en = 1'b1;
			end
			ST_KS_RD_J: begin
				perm_rd_en   = 1'b1;
				perm_rd_addr = j_new;
			end
			ST_KS_WR_I: begin
				perm_wr_en   = 1'b1;
				perm_wr_data = perm_rd_q;
			end
			ST_KS_WR_J: begin
				perm_wr_en   = 1'b1;
				perm_wr_addr = j_q;
				perm_wr_data = si_q;
			end
			ST_KG_RD_A: begin
				perm_rd_en   = 1'b1;
				perm_rd_addr = a_new;
			end
			ST_KG_RD_B: begin
				perm_rd_en   = 1'b1;
				perm_rd_addr = b_new;
			end
			ST_KG_WR_A: begin
				perm_rd_en   = 1'b1;
				perm_rd_addr = t_addr;
				perm_wr_en   = 1'b1;
				perm_wr_addr = a_q;
				perm_wr_data = perm_rd_q;
			end
			ST_KG_WR_B: begin
				perm_wr_en   = 1'b1;
				perm_wr_addr = b_q;
				perm_wr_data = sa_q;
			end
			default: begin
				perm_rd_en = 1'b0;
			end
		endcase
	end

	// Permutation table memory, one read and one write port.
	always_ff @(posedge clk) begin
		if (perm_wr_en) begin
			perm_mem[perm_wr_addr] <= perm_wr_data;
		end
		if (perm_rd_en) begin
			perm_rd_q <= perm_mem[perm_rd_addr];
		end
	end

	// Key store memory.
	always_ff @(posedge clk) begin
		if (key_wr_en) begin
			key_mem[key_count_q[KA_W-1:0]] <= s_axis_tdata;
		end
		if (key_rd_en) begin
			key_rd_q <= key_mem[key_idx_q[KA_W-1:0]];
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			drop_count_q <= cfg_data;
		end
	end

	// Output register, loaded by a finished data byte and freed by a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			out_byte_q  <= data_q ^ ks_byte;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer with its control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_count_q <= '0;
			key_idx_q   <= '0;
			drop_cnt_q  <= '0;
			i_q         <= '0;
			j_q         <= '0;
			a_q         <= '0;
			b_q         <= '0;
			is_data_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						data_q <= s_axis_tdata;
						if (s_axis_tuser[0] == FUNC_DATA) begin
							is_data_q <= 1'b1;
							state_q   <= ST_KG_RD_A;
						end else begin
							if (key_wr_en) begin
								key_count_q <= key_count_q + 1'b1;
							end
							if (s_axis_tlast) begin
								i_q     <= '0;
								state_q <= ST_INIT;
							end
						end
					end
				end
				ST_INIT: begin
					// Identity permutation, one entry per cycle.
					i_q <= i_q + 1'b1;
					if (i_q == PA_W'(PERM_DEPTH - 1)) begin
						j_q       <= '0;
						a_q       <= '0;
						b_q       <= '0;
						key_idx_q <= '0;
						state_q   <= ST_KS_RD_I;
					end
				end
				ST_KS_RD_I: begin
					state_q <= ST_KS_RD_J;
				end
				ST_KS_RD_J: begin
					si_q    <= perm_rd_q;
					j_q     <= j_new;
					state_q <= ST_KS_WR_I;
					// Key index wraps at the key length.
					if (key_idx_inc >= key_count_q) begin
						key_idx_q <= '0;
					end else begin
						key_idx_q <= key_idx_inc;
					end
				end
				ST_KS_WR_I: begin
					state_q <= ST_KS_WR_J;
				end
				ST_KS_WR_J: begin
					i_q <= i_q + 1'b1;
					if (i_q == PA_W'(PERM_DEPTH - 1)) begin
						key_count_q <= '0;
						drop_cnt_q  <= drop_count_q;
						state_q     <= ST_DROP_CHK;
					end else begin
						state_q <= ST_KS_RD_I;
					end
				end
				ST_DROP_CHK: begin
					if (drop_cnt_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						drop_cnt_q <= drop_cnt_q - 1'b1;
						is_data_q  <= 1'b0;
						state_q    <= ST_KG_RD_A;
					end
				end
				ST_KG_RD_A: begin
					a_q     <= a_new;
					state_q <= ST_KG_RD_B;
				end
				ST_KG_RD_B: begin
					sa_q    <= perm_rd_q;
					b_q     <= b_new;
					state_q <= ST_KG_WR_A;
				end
				ST_KG_WR_A: begin
					sb_q    <= perm_rd_q;
					fwd_a_q <= (t_addr == a_q);
					fwd_b_q <= (t_addr == b_q);
					state_q <= ST_KG_WR_B;
				end
				ST_KG_WR_B: begin
					// A data byte waits here until the output register is free.
					if (!is_data_q) begin
						state_q <= ST_DROP_CHK;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
